// ===== hw/rtl/wsia_pkg.sv =====
// shared types, codes and helper functions of the word-size limited integer alu
`timescale 1ns / 1ps
package wsia_pkg;

  localparam int unsigned DataW        = 64;
  localparam int unsigned HalfW        = DataW / 2;
  localparam int unsigned TagW         = 12;
  localparam int unsigned WsW          = 6;
  localparam int unsigned FuncW        = 4;
  localparam int unsigned DivSteps     = DataW;
  localparam int unsigned DefQueueDepth = 2;
  localparam logic [WsW-1:0] WsReset   = 6'd63;
  localparam logic [WsW-1:0] WsMin     = 6'd1;

  typedef enum logic [FuncW-1:0] {
    FUNC_OR  = 4'd0,
    FUNC_AND = 4'd1,
    FUNC_XOR = 4'd2,
    FUNC_LSL = 4'd3,
    FUNC_LSR = 4'd4,
    FUNC_ASR = 4'd5,
    FUNC_NOT = 4'd6,
    FUNC_ADD = 4'd7,
    FUNC_SUB = 4'd8,
    FUNC_MUL = 4'd9,
    FUNC_DIV = 4'd10
  } func_e;

  typedef enum logic [2:0] {
    CLS_BITWISE,
    CLS_SHIFT,
    CLS_ADDSUB,
    CLS_MUL,
    CLS_DIV,
    CLS_NONE
  } cls_e;

  typedef struct packed {
    logic [FuncW-1:0] func;
    cls_e             cls;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [TagW-1:0]  tag;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] res;
    logic [HalfW-1:0] mx1;
    logic [HalfW-1:0] mx2;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] nq;
    logic [DataW-1:0] dvs;
    logic             qneg;
    logic             dz;
    cls_e             cls;
    logic [TagW-1:0]  tag;
  } stage_t;

  // ones in bits below n, all ones for n of 64 or more
  function automatic logic [DataW-1:0] low_mask(input logic [WsW:0] n);
    logic [DataW-1:0] m;
    if (n[WsW]) begin
      m = '1;
    end else begin
      m = (DataW'(1) << n[WsW-1:0]) - DataW'(1);
    end
    return m;
  endfunction

  // bit pos is the sign: extend from it, otherwise keep the bits below it
  function automatic logic [DataW-1:0] extend_at(input logic [DataW-1:0] x,
                                                 input logic [WsW-1:0]   pos);
    logic [DataW-1:0] m;
    m = low_mask({1'b0, pos});
    return x[pos] ? (x | ~m) : (x & m);
  endfunction

endpackage

// ===== hw/rtl/word_size_integer_alu.sv =====
// top level of the word-size limited integer alu
`timescale 1ns / 1ps
// Takes one request per cycle while not stalled, one result each, in order.
// Every request runs through the same pipeline of 66 register stages: an
// operand stage, 64 restoring divider stages that produce one quotient bit
// each, and the result register; the multiplier's cross products are summed
// in the first divider stage. Throughput is one request per cycle while the
// pipeline is not held. The whole pipeline holds while a result waits on
// out_stall_i; the small request queue in front keeps taking requests until
// it fills.
// word_size is written through the cfg channel, clamps to 1..63 and must only
// change while no request is in flight.
module word_size_integer_alu #(
  parameter int unsigned QueueDepth = wsia_pkg::DefQueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [wsia_pkg::FuncW-1:0] func_i,
  input  logic [wsia_pkg::DataW-1:0] operand_a_i,
  input  logic [wsia_pkg::DataW-1:0] operand_b_i,
  input  logic [wsia_pkg::TagW-1:0]  format_tag_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [wsia_pkg::DataW-1:0] result_o,
  output logic [wsia_pkg::TagW-1:0]  result_tag_o,
  output logic                       divide_by_zero_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [wsia_pkg::WsW-1:0]   cfg_word_size_i
);
  import wsia_pkg::*;

  logic [WsW-1:0] ws_q;
  req_t           req;
  logic           req_valid;
  logic           pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= WsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ws_q <= (cfg_word_size_i == '0) ? WsMin : cfg_word_size_i;
    end
  end

  wsia_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .format_tag_i(format_tag_i),
    .req_o       (req),
    .req_valid_o (req_valid),
    .pop_i       (pop)
  );

  wsia_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ws_i            (ws_q),
    .req_i           (req),
    .req_valid_i     (req_valid),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_o        (result_o),
    .result_tag_o    (result_tag_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

endmodule

// ===== hw/rtl/wsia_front.sv =====
// front end: classifies requests and queues them for the execution pipeline
`timescale 1ns / 1ps
module wsia_front #(
  parameter int unsigned Depth = wsia_pkg::DefQueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [wsia_pkg::FuncW-1:0]  func_i,
  input  logic [wsia_pkg::DataW-1:0]  operand_a_i,
  input  logic [wsia_pkg::DataW-1:0]  operand_b_i,
  input  logic [wsia_pkg::TagW-1:0]   format_tag_i,
  output wsia_pkg::req_t              req_o,
  output logic                        req_valid_o,
  input  logic                        pop_i
);
  import wsia_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  cls_e            cls;
  req_t            req_new;

  always_comb begin
    unique case (func_i) inside
      FUNC_OR, FUNC_AND, FUNC_XOR, FUNC_NOT: cls = CLS_BITWISE;
      FUNC_LSL, FUNC_LSR, FUNC_ASR:          cls = CLS_SHIFT;
      FUNC_ADD, FUNC_SUB:                    cls = CLS_ADDSUB;
      FUNC_MUL:                              cls = CLS_MUL;
      FUNC_DIV:                              cls = CLS_DIV;
      default:                               cls = CLS_NONE;
    endcase
  end

  assign req_new = '{func: func_i, cls: cls, a: operand_a_i, b: operand_b_i,
                     tag: format_tag_i};

  assign in_stall_o  = (cnt_q == CntW'(Depth));
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= req_new;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("request queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> req_valid_o)
    else $error("pop from empty request queue");

endmodule

// ===== hw/rtl/wsia_back.sv =====
// back end: operand stage, multiplier, pipelined restoring divider, result stage
`timescale 1ns / 1ps
module wsia_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [wsia_pkg::WsW-1:0]   ws_i,
  input  wsia_pkg::req_t             req_i,
  input  logic                       req_valid_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [wsia_pkg::DataW-1:0] result_o,
  output logic [wsia_pkg::TagW-1:0]  result_tag_o,
  output logic                       divide_by_zero_o
);
  import wsia_pkg::*;

  stage_t            st_q [DivSteps+1];
  logic [DivSteps:0] v_q;
  logic              out_valid_q;
  logic [DataW-1:0]  result_q;
  logic [TagW-1:0]   tag_q;
  logic              dz_q;
  logic              en;

  // operand stage signals
  logic [DataW-1:0] a, b, cnt, shl_a, sar_a, a_lsr, shr_al, shl_al;
  logic [DataW-1:0] r_asr, dpos, r_simple, mag_a;
  logic [WsW-1:0]   c6;
  logic             b_neg, b_pos, big;
  stage_t           s0_d;

  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && req_valid_i;

  always_comb begin
    a      = req_i.a;
    b      = req_i.b;
    b_neg  = b[DataW-1];
    b_pos  = !b_neg && (b != '0);
    cnt    = b_neg ? (DataW'(0) - b) : b;
    big    = |cnt[DataW-1:WsW];
    c6     = cnt[WsW-1:0];
    shl_a  = big ? '0 : (a << c6);
    sar_a  = big ? {DataW{a[DataW-1]}} : DataW'($signed(a) >>> c6);
    a_lsr  = a & low_mask({1'b0, ws_i} + (WsW+1)'(1));
    shr_al = big ? '0 : (a_lsr >> c6);
    shl_al = big ? '0 : (a_lsr << c6);
    r_asr  = b_pos ? sar_a : shl_a;
    // sign position for asr sits at word size minus b, the signed count
    dpos   = DataW'(ws_i) - b;
    if (dpos[DataW-1:WsW] == '0) begin
      if (r_asr[dpos[WsW-1:0]]) begin
        r_asr = r_asr | ~low_mask({1'b0, dpos[WsW-1:0]});
      end else begin
        r_asr = r_asr & low_mask({1'b0, ws_i});
      end
    end else begin
      r_asr = r_asr & low_mask({1'b0, ws_i});
    end

    case (req_i.func)
      FUNC_OR:  r_simple = extend_at(a | b, ws_i);
      FUNC_AND: r_simple = extend_at(a & b, ws_i);
      FUNC_XOR: r_simple = extend_at(a ^ b, ws_i);
      FUNC_NOT: r_simple = extend_at(~a, ws_i);
      FUNC_LSL: r_simple = extend_at(b_pos ? shl_a : sar_a, ws_i);
      FUNC_LSR: r_simple = extend_at(b_pos ? shr_al : shl_al, ws_i);
      FUNC_ASR: r_simple = r_asr;
      FUNC_ADD: r_simple = extend_at(a + b, ws_i);
      FUNC_SUB: r_simple = extend_at(a - b, ws_i);
      default:  r_simple = '0;
    endcase

    mag_a     = a[DataW-1] ? (DataW'(0) - a) : a;
    s0_d.res  = (req_i.cls == CLS_MUL) ? (a[HalfW-1:0] * b[HalfW-1:0]) : r_simple;
    // cross products only matter in their low half
    s0_d.mx1  = HalfW'(a[DataW-1:HalfW] * b[HalfW-1:0]);
    s0_d.mx2  = HalfW'(a[HalfW-1:0] * b[DataW-1:HalfW]);
    s0_d.rem  = '0;
    s0_d.nq   = mag_a;
    s0_d.dvs  = cnt;
    s0_d.qneg = a[DataW-1] != b_neg;
    s0_d.dz   = (req_i.cls == CLS_DIV) && (b == '0);
    s0_d.cls  = req_i.cls;
    s0_d.tag  = req_i.tag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= s0_d;
    end
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    stage_t           nx;
    logic [DataW-1:0] shifted;
    logic             qbit;

    always_comb begin
      nx      = st_q[k-1];
      // one quotient bit per stage
      shifted = {st_q[k-1].rem[DataW-2:0], st_q[k-1].nq[DataW-1]};
      qbit    = (shifted >= st_q[k-1].dvs);
      nx.rem  = qbit ? (shifted - st_q[k-1].dvs) : shifted;
      nx.nq   = {st_q[k-1].nq[DataW-2:0], qbit};
      if (k == 1 && st_q[k-1].cls == CLS_MUL) begin
        nx.res = st_q[k-1].res + {st_q[k-1].mx1 + st_q[k-1].mx2, HalfW'(0)};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k] <= nx;
      end
    end
  end

  stage_t           fin;
  logic [DataW-1:0] fin_res;

  always_comb begin
    fin = st_q[DivSteps];
    case (fin.cls)
      CLS_MUL: fin_res = extend_at(fin.res, ws_i);
      CLS_DIV: fin_res = fin.dz ? '0
                         : extend_at(fin.qneg ? (DataW'(0) - fin.nq) : fin.nq, ws_i);
      default: fin_res = fin.res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q <= fin_res;
      tag_q    <= fin.tag;
      dz_q     <= fin.dz;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_o         = result_q;
  assign result_tag_o     = tag_q;
  assign divide_by_zero_o = dz_q;

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o |-> result_o == '0)
    else $error("divide by zero with nonzero result");

  a_pop_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> v_q[0])
    else $error("popped request did not enter the pipeline");

endmodule
